// File: hw/rtl/rle_pattern_run_decoder_defines.svh
// Assertion macros for the run-length pattern decoder.
`ifndef RLE_PATTERN_RUN_DECODER_DEFINES_SVH
`define RLE_PATTERN_RUN_DECODER_DEFINES_SVH

`ifndef SYNTH

// cons must hold in the same cycle as ante
`define RPRD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define RPRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RPRD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define RPRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hw/rtl/rprd_pkg.sv
`default_nettype none

package rprd_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COUNT_W = 12;
  localparam int unsigned FIELD_W = 12;
  localparam int unsigned STATE_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
  localparam logic [CHAR_W-1:0] CH_DOLL  = 8'h24;
  localparam logic [CHAR_W-1:0] CH_DEAD  = 8'h62;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_LIVE  = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;

  localparam logic [STATE_W-1:0] STATE_LIVE = 5'd1;

  typedef enum logic [0:0] {
    CFG_X_ORIGIN = 1'b0,
    CFG_Y_ORIGIN = 1'b1
  } cfg_idx_t;

endpackage

`default_nettype wire

// File: hw/rtl/rle_pattern_run_decoder.sv
// Run-length pattern decoder, one character per request.
// Pipeline: input register, then result register, between input accept and result valid.
// Throughput: one character per cycle; the only stall source is a held result register.
// Reset (synchronous, rst_n low): origins, run count and offsets clear to zero,
// both pipeline stages empty.
`default_nettype none

`include "rle_pattern_run_decoder_defines.svh"

module rle_pattern_run_decoder #(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [0:0]                     cfg_index,
  input  wire logic [rprd_pkg::FIELD_W-1:0]   cfg_wdata,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [rprd_pkg::CHAR_W-1:0]    in_character,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic [rprd_pkg::FIELD_W-1:0]   out_run_x,
  output      logic [rprd_pkg::FIELD_W-1:0]   out_run_y,
  output      logic [rprd_pkg::COUNT_W-1:0]   out_run_length,
  output      logic [rprd_pkg::STATE_W-1:0]   out_cell_state,
  output      logic                           out_pattern_end
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned AW   = (CW > rprd_pkg::FIELD_W) ? CW : rprd_pkg::FIELD_W;
  localparam int unsigned SUMW = AW + 1;
  localparam logic [SUMW-1:0] COORD_MAX_EXT = {{(SUMW-CW){1'b0}}, {CW{1'b1}}};
  localparam logic [CW-1:0]   COORD_MAX     = {CW{1'b1}};

  // saturating add of a coordinate and an amount as wide as the wider of the two
  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                            input logic [AW-1:0] b);
    logic [SUMW-1:0] s;
    s = SUMW'(a) + SUMW'(b);
    return (s > COORD_MAX_EXT) ? COORD_MAX : s[CW-1:0];
  endfunction

  function automatic logic [rprd_pkg::FIELD_W-1:0] to_field(input logic [CW-1:0] v);
    logic [SUMW-1:0] e;
    e = SUMW'(v);
    return e[rprd_pkg::FIELD_W-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [CW-1:0]   x_origin_r;
  logic [CW-1:0]   y_origin_r;
  logic [SUMW-1:0] cfg_ext;
  logic [CW-1:0]   cfg_clamped;

  assign cfg_ext     = SUMW'(cfg_wdata);
  assign cfg_clamped = (cfg_ext > COORD_MAX_EXT) ? COORD_MAX : cfg_ext[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= '0;
      y_origin_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rprd_pkg::CFG_X_ORIGIN: x_origin_r <= cfg_clamped;
        rprd_pkg::CFG_Y_ORIGIN: y_origin_r <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input stage
  logic                         s1_valid_r;
  logic [rprd_pkg::CHAR_W-1:0]  char_r;
  logic                         s1_adv;
  logic                         s1_emit;
  logic                         out_free;
  logic                         out_valid_r;

  assign out_free = !out_valid_r || !out_stall;
  // an item that produces nothing never waits on the result side
  assign s1_adv   = s1_valid_r && (!s1_emit || out_free);
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_r <= in_character;
    end
  end

  // ---------------------------------------------------------------- decode
  logic [rprd_pkg::COUNT_W-1:0]  dc_r, dc_nxt;
  logic [CW-1:0]                 col_r, col_nxt;
  logic [CW-1:0]                 row_r, row_nxt;
  logic [rprd_pkg::COUNT_W-1:0]  n;
  logic [rprd_pkg::COUNT_W+3:0]  dc_acc;
  logic                          is_end, is_ws, is_digit, is_skip, is_row, is_live, is_letter;
  logic [rprd_pkg::FIELD_W-1:0]  res_x, res_y;
  logic [rprd_pkg::COUNT_W-1:0]  res_len;
  logic [rprd_pkg::STATE_W-1:0]  res_state;
  logic                          res_end;

  assign is_end    = (char_r == rprd_pkg::CH_NUL) || (char_r == rprd_pkg::CH_BANG);
  assign is_ws     = (char_r == rprd_pkg::CH_SPACE) || (char_r == rprd_pkg::CH_LF) ||
                     (char_r == rprd_pkg::CH_TAB);
  assign is_digit  = (char_r >= rprd_pkg::CH_0) && (char_r <= rprd_pkg::CH_9);
  assign is_skip   = (char_r == rprd_pkg::CH_DEAD) || (char_r == rprd_pkg::CH_DOT);
  assign is_row    = (char_r == rprd_pkg::CH_DOLL);
  assign is_live   = (char_r == rprd_pkg::CH_LIVE);
  assign is_letter = (char_r >= rprd_pkg::CH_A) && (char_r <= rprd_pkg::CH_Z);

  assign n = (dc_r == '0) ? rprd_pkg::COUNT_W'(1) : dc_r;
  // count * 10 + digit as shifts and adds
  assign dc_acc = ((rprd_pkg::COUNT_W+4)'(dc_r) << 3) + ((rprd_pkg::COUNT_W+4)'(dc_r) << 1) +
                  (rprd_pkg::COUNT_W+4)'(char_r[3:0]);

  always_comb begin
    dc_nxt    = dc_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    s1_emit   = 1'b0;
    res_x     = '0;
    res_y     = '0;
    res_len   = '0;
    res_state = '0;
    res_end   = 1'b0;
    if (is_end) begin
      s1_emit = 1'b1;
      res_end = 1'b1;
      dc_nxt  = '0;
      col_nxt = '0;
      row_nxt = '0;
    end else if (is_ws) begin
      dc_nxt = dc_r;
    end else if (is_digit) begin
      dc_nxt = (dc_acc > (rprd_pkg::COUNT_W+4)'(rprd_pkg::COUNT_MAX)) ?
               rprd_pkg::COUNT_MAX : dc_acc[rprd_pkg::COUNT_W-1:0];
    end else begin
      dc_nxt = '0;
      if (is_skip) begin
        col_nxt = sat_add(col_r, AW'(n));
      end else if (is_row) begin
        row_nxt = sat_add(row_r, AW'(n));
        col_nxt = '0;
      end else if (is_live || is_letter) begin
        s1_emit   = 1'b1;
        res_x     = to_field(sat_add(x_origin_r, AW'(col_r)));
        res_y     = to_field(sat_add(y_origin_r, AW'(row_r)));
        res_len   = n;
        // 'A'..'Z' map to 1..26 through the low five bits
        res_state = is_live ? rprd_pkg::STATE_LIVE : char_r[rprd_pkg::STATE_W-1:0];
        col_nxt   = sat_add(col_r, AW'(n));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r  <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (s1_adv) begin
      dc_r  <= dc_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_run_x       <= res_x;
      out_run_y       <= res_y;
      out_run_length  <= res_len;
      out_cell_state  <= res_state;
      out_pattern_end <= res_end;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------- checks
  `RPRD_ASSERT_IMPL(a_end_fields, clk, rst_n, out_valid_r && out_pattern_end,
    out_run_x == '0 && out_run_y == '0 && out_run_length == '0 && out_cell_state == '0,
    "end marker carries nonzero fields")
  `RPRD_ASSERT_IMPL(a_run_fields, clk, rst_n, out_valid_r && !out_pattern_end,
    out_run_length != '0 && out_cell_state != '0,
    "run command with zero length or state")
  `RPRD_ASSERT_NEXT(a_end_rewind, clk, rst_n, s1_adv && is_end,
    dc_r == '0 && col_r == '0 && row_r == '0,
    "end marker did not rewind")
  `RPRD_ASSERT_IMPL(a_hold_blocked, clk, rst_n,
    s1_valid_r && s1_emit && out_valid_r && out_stall, in_stall && !s1_adv,
    "pending run lost while result blocked")

endmodule

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb;

  localparam int unsigned COORD_TOP = 4095;
  localparam int unsigned RUN_LATENCY = 4;

  typedef struct packed {
    logic [rprd_pkg::FIELD_W-1:0] run_x;
    logic [rprd_pkg::FIELD_W-1:0] run_y;
    logic [rprd_pkg::COUNT_W-1:0] run_length;
    logic [rprd_pkg::STATE_W-1:0] cell_state;
    logic                         pattern_end;
  } run_cmd_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = 1'b0;
  logic [rprd_pkg::FIELD_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [rprd_pkg::CHAR_W-1:0] in_character = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [rprd_pkg::FIELD_W-1:0] out_run_x;
  logic [rprd_pkg::FIELD_W-1:0] out_run_y;
  logic [rprd_pkg::COUNT_W-1:0] out_run_length;
  logic [rprd_pkg::STATE_W-1:0] out_cell_state;
  logic out_pattern_end;

  rle_pattern_run_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_character   (in_character),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_run_x      (out_run_x),
    .out_run_y      (out_run_y),
    .out_run_length (out_run_length),
    .out_cell_state (out_cell_state),
    .out_pattern_end(out_pattern_end)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // decoder shadow state
  int unsigned x_org = 0;
  int unsigned y_org = 0;
  int unsigned pend_count = 0;
  int unsigned col_off = 0;
  int unsigned row_off = 0;

  run_cmd_t run_q[$];
  int unsigned errors = 0;
  int unsigned burst_left = 0;
  int unsigned chars_sent = 0;

  function automatic int unsigned coord_add(input int unsigned a, input int unsigned b);
    return (a + b > COORD_TOP) ? COORD_TOP : a + b;
  endfunction

  function automatic void decode_char(input logic [rprd_pkg::CHAR_W-1:0] c);
    int unsigned n;
    int unsigned t;
    run_cmd_t r;
    r = '0;
    if (c == rprd_pkg::CH_BANG || c == rprd_pkg::CH_NUL) begin
      r.pattern_end = 1'b1;
      run_q.push_back(r);
      pend_count = 0;
      col_off = 0;
      row_off = 0;
      return;
    end
    if (c == rprd_pkg::CH_SPACE || c == rprd_pkg::CH_LF || c == rprd_pkg::CH_TAB) return;
    if (c >= rprd_pkg::CH_0 && c <= rprd_pkg::CH_9) begin
      t = pend_count * 10 + int'(c - rprd_pkg::CH_0);
      pend_count = (t > rprd_pkg::COUNT_MAX) ? rprd_pkg::COUNT_MAX : t;
      return;
    end
    n = (pend_count == 0) ? 1 : pend_count;
    pend_count = 0;
    if (c == rprd_pkg::CH_DEAD || c == rprd_pkg::CH_DOT) begin
      col_off = coord_add(col_off, n);
      return;
    end
    if (c == rprd_pkg::CH_DOLL) begin
      row_off = coord_add(row_off, n);
      col_off = 0;
      return;
    end
    if (c == rprd_pkg::CH_LIVE) r.cell_state = rprd_pkg::STATE_LIVE;
    else if (c >= rprd_pkg::CH_A && c <= rprd_pkg::CH_Z)
      r.cell_state = rprd_pkg::STATE_LIVE + rprd_pkg::STATE_W'(c - rprd_pkg::CH_A);
    else return;
    r.run_x = rprd_pkg::FIELD_W'(coord_add(x_org, col_off));
    r.run_y = rprd_pkg::FIELD_W'(coord_add(y_org, row_off));
    r.run_length = rprd_pkg::COUNT_W'(n);
    run_q.push_back(r);
    col_off = coord_add(col_off, n);
  endfunction

  // receiver back-pressure, picking a new pattern whenever the low byte of stall_cyc is zero
  stall_mode_t stall_mode = STALL_NONE;
  logic [11:0] stall_cyc = '0;
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1'b1;
    if (stall_cyc[7:0] == 8'd0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 9) < 3);
      STALL_PERIODIC: out_stall <= (stall_cyc % 3 == 0);
      default:        out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  always @(posedge clk) begin
    run_cmd_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (run_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result x=%0d y=%0d len=%0d st=%0d end=%0b", $time,
                 out_run_x, out_run_y, out_run_length, out_cell_state, out_pattern_end);
      end else begin
        want = run_q.pop_front();
        if (out_run_x !== want.run_x) begin
          errors++;
          $display("%0t: run_x exp %0d got %0d", $time, want.run_x, out_run_x);
        end
        if (out_run_y !== want.run_y) begin
          errors++;
          $display("%0t: run_y exp %0d got %0d", $time, want.run_y, out_run_y);
        end
        if (out_run_length !== want.run_length) begin
          errors++;
          $display("%0t: run_length exp %0d got %0d", $time, want.run_length, out_run_length);
        end
        if (out_cell_state !== want.cell_state) begin
          errors++;
          $display("%0t: cell_state exp %0d got %0d", $time, want.cell_state, out_cell_state);
        end
        if (out_pattern_end !== want.pattern_end) begin
          errors++;
          $display("%0t: pattern_end exp %0b got %0b", $time, want.pattern_end,
                   out_pattern_end);
        end
      end
    end
  end

  // one request; returns at the edge where it is taken
  task automatic send_char(input logic [rprd_pkg::CHAR_W-1:0] c);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    decode_char(c);
    chars_sent++;
    in_valid <= 1'b1;
    in_character <= c;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_count(input int unsigned v);
    send_text($sformatf("%0d", v));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (run_q.size() != 0) @(posedge clk);
    repeat (RUN_LATENCY) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller drops it after its last write
  task automatic write_reg(input rprd_pkg::cfg_idx_t idx,
                           input logic [rprd_pkg::FIELD_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    if (idx == rprd_pkg::CFG_X_ORIGIN) x_org = (v > COORD_TOP) ? COORD_TOP : v;
    else y_org = (v > COORD_TOP) ? COORD_TOP : v;
  endtask

  task automatic set_origin(input logic [rprd_pkg::FIELD_W-1:0] x,
                            input logic [rprd_pkg::FIELD_W-1:0] y);
    drain();
    write_reg(rprd_pkg::CFG_X_ORIGIN, x);
    write_reg(rprd_pkg::CFG_Y_ORIGIN, y);
    cfg_we <= 1'b0;
  endtask

  // every symbol class, whitespace inside a count, zero count, unknown bytes, NUL end
  task automatic test_symbols();
    send_text("3o2b.A$");
    send_char(rprd_pkg::CH_TAB);
    send_text("1 2Z0o");
    send_char(rprd_pkg::CH_LF);
    send_text("x5$Go");
    send_char(8'hFF);
    send_text("o!");
    send_char(rprd_pkg::CH_NUL);
  endtask

  task automatic test_saturation();
    send_text("99999o");
    send_count(4000);
    send_text("b200.o$");
    send_count(4095);
    send_text("$Bo!");
  endtask

  task automatic test_origins();
    set_origin(12'hFFF, 12'hFFF);
    send_text("o2$3bC!");
    set_origin(12'd0, 12'hFFF);
    send_text("2o$o!");
    set_origin(12'd4000, 12'd7);
    send_text("90b3o10$Y!");
  endtask

  task automatic send_pattern(inout int unsigned budget);
    int unsigned roll;
    int unsigned sym;
    while (budget > 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        sym = $urandom_range(0, 2);
        send_char(sym == 0 ? rprd_pkg::CH_SPACE :
                  (sym == 1 ? rprd_pkg::CH_LF : rprd_pkg::CH_TAB));
        budget--;
      end else if (roll < 13) begin
        send_char(rprd_pkg::CHAR_W'($urandom_range(0, 255)));
        budget--;
      end else begin
        if ($urandom_range(0, 1) == 1) begin
          if ($urandom_range(0, 19) == 0) send_count($urandom_range(0, 99999));
          else send_count($urandom_range(0, 30));
          budget = (budget > 2) ? budget - 2 : 0;
        end
        sym = $urandom_range(0, 99);
        if (sym < 40) send_char(rprd_pkg::CH_LIVE);
        else if (sym < 60)
          send_char(rprd_pkg::CH_A + rprd_pkg::CHAR_W'($urandom_range(0, 25)));
        else if (sym < 75) send_char(rprd_pkg::CH_DEAD);
        else if (sym < 85) send_char(rprd_pkg::CH_DOT);
        else send_char(rprd_pkg::CH_DOLL);
        if (budget > 0) budget--;
      end
      if ($urandom_range(0, 39) == 0) break;
    end
    send_char(($urandom_range(0, 3) == 0) ? rprd_pkg::CH_NUL : rprd_pkg::CH_BANG);
  endtask

  task automatic test_random();
    int unsigned budget;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_origin(12'd0, 12'd0);
        1: set_origin(12'hFFF, 12'd0);
        2: set_origin(12'd0, 12'hFFF);
        3: set_origin(12'hFFF, 12'hFFF);
        default: set_origin(rprd_pkg::FIELD_W'($urandom_range(0, 4095)),
                            rprd_pkg::FIELD_W'($urandom_range(0, 4095)));
      endcase
      budget = 150;
      while (budget > 0) send_pattern(budget);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_symbols();
    test_saturation();
    test_origins();
    test_random();
    drain();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/rprd_pkg.sv
hw/rtl/rle_pattern_run_decoder.sv
bench/tb.sv
